// ===== design/assert_macros.svh =====
// assert_macros.svh: assertion macros for the ellipse outline rasterizer.
// Expects signals clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define EOR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define EOR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/eor_pkg.sv =====
// eor_pkg: item types, microcode control word and microprogram ROM
// for the ellipse outline rasterizer. No dependencies.
package eor_pkg;

  localparam int unsigned RADIUS_BITS_DEF = 10;
  localparam int unsigned COORD_BITS_DEF  = 16;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic        [9:0]  radius_h;
    logic        [9:0]  radius_v;
    logic        [15:0] pixel_colour;
  } in_item_t;

  typedef struct packed {
    logic               pixel_valid;
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic        [15:0] out_colour;
    logic               last_of_step;
    logic               finished;
  } out_item_t;

  // Multiplier operand selection.
  typedef enum logic [2:0] {
    MUL_OFF, MUL_AA, MUL_BB, MUL_HB, MUL_VX, MUL_HY
  } mul_op_t;

  // Datapath operation of one microstep.
  typedef enum logic [3:0] {
    DP_NOP, DP_LD_SQH, DP_LD_SQV, DP_LD_ERR, DP_LD_CRIT,
    DP_CMP_A, DP_CMP_B, DP_CMP_C, DP_EMIT, DP_EMPTY,
    DP_DX, DP_EX, DP_DY, DP_EY
  } dp_op_t;

  // Quadrant of an emitted pixel: sign of x offset, sign of y offset.
  typedef enum logic [1:0] {Q_PP, Q_NN, Q_PN, Q_NP} quad_t;

  typedef enum logic [2:0] {
    J_NEXT, J_WAIT, J_GOTO, J_IF_LAST, J_IF_NOX, J_IF_NOY
  } jmp_t;

  typedef logic [4:0] upc_t;

  localparam upc_t U_IDLE  = 5'd0;
  localparam upc_t U_ST0   = 5'd1;
  localparam upc_t U_ST1   = 5'd2;
  localparam upc_t U_ST2   = 5'd3;
  localparam upc_t U_ST3   = 5'd4;
  localparam upc_t U_ST4   = 5'd5;
  localparam upc_t U_SP0   = 5'd6;
  localparam upc_t U_SP1   = 5'd7;
  localparam upc_t U_SP2   = 5'd8;
  localparam upc_t U_SP3   = 5'd9;
  localparam upc_t U_E0    = 5'd10;
  localparam upc_t U_E1    = 5'd11;
  localparam upc_t U_E2    = 5'd12;
  localparam upc_t U_E3    = 5'd13;
  localparam upc_t U_UX0   = 5'd14;
  localparam upc_t U_UX1   = 5'd15;
  localparam upc_t U_UY0   = 5'd16;
  localparam upc_t U_UY1   = 5'd17;
  localparam upc_t U_EMPTY = 5'd18;

  typedef struct packed {
    mul_op_t mul;
    dp_op_t  op;
    quad_t   quad;
    jmp_t    jmp;
    upc_t    target;
  } ctrl_t;

  function automatic ctrl_t cw(mul_op_t m, dp_op_t o, quad_t q, jmp_t j, upc_t t);
    ctrl_t c;
    c.mul    = m;
    c.op     = o;
    c.quad   = q;
    c.jmp    = j;
    c.target = t;
    return c;
  endfunction

  // Microprogram: start routine, step routine (products, compares,
  // mirrored emission, advance), and the empty result of an idle step.
  function automatic ctrl_t ucode(upc_t pc);
    ctrl_t c;
    case (pc)
      U_IDLE:  c = cw(MUL_OFF, DP_NOP,     Q_PP, J_WAIT,    U_IDLE);
      U_ST0:   c = cw(MUL_AA,  DP_NOP,     Q_PP, J_NEXT,    U_IDLE);
      U_ST1:   c = cw(MUL_BB,  DP_LD_SQH,  Q_PP, J_NEXT,    U_IDLE);
      U_ST2:   c = cw(MUL_HB,  DP_LD_SQV,  Q_PP, J_NEXT,    U_IDLE);
      U_ST3:   c = cw(MUL_OFF, DP_LD_ERR,  Q_PP, J_NEXT,    U_IDLE);
      U_ST4:   c = cw(MUL_OFF, DP_LD_CRIT, Q_PP, J_GOTO,    U_IDLE);
      U_SP0:   c = cw(MUL_VX,  DP_NOP,     Q_PP, J_NEXT,    U_IDLE);
      U_SP1:   c = cw(MUL_HY,  DP_CMP_A,   Q_PP, J_NEXT,    U_IDLE);
      U_SP2:   c = cw(MUL_OFF, DP_CMP_B,   Q_PP, J_NEXT,    U_IDLE);
      U_SP3:   c = cw(MUL_OFF, DP_CMP_C,   Q_PP, J_NEXT,    U_IDLE);
      U_E0:    c = cw(MUL_OFF, DP_EMIT,    Q_PP, J_IF_LAST, U_UX0);
      U_E1:    c = cw(MUL_OFF, DP_EMIT,    Q_NN, J_IF_LAST, U_UX0);
      U_E2:    c = cw(MUL_OFF, DP_EMIT,    Q_PN, J_NEXT,    U_IDLE);
      U_E3:    c = cw(MUL_OFF, DP_EMIT,    Q_NP, J_NEXT,    U_IDLE);
      U_UX0:   c = cw(MUL_OFF, DP_DX,      Q_PP, J_IF_NOX,  U_UY0);
      U_UX1:   c = cw(MUL_OFF, DP_EX,      Q_PP, J_NEXT,    U_IDLE);
      U_UY0:   c = cw(MUL_OFF, DP_DY,      Q_PP, J_IF_NOY,  U_IDLE);
      U_UY1:   c = cw(MUL_OFF, DP_EY,      Q_PP, J_GOTO,    U_IDLE);
      U_EMPTY: c = cw(MUL_OFF, DP_EMPTY,   Q_PP, J_GOTO,    U_IDLE);
      default: c = cw(MUL_OFF, DP_NOP,     Q_PP, J_GOTO,    U_IDLE);
    endcase
    return c;
  endfunction

endpackage

// ===== design/ellipse_outline_rasterizer.sv =====
// ellipse_outline_rasterizer: microcoded midpoint ellipse outline walker.
// Depends on eor_pkg (types, microprogram ROM) and assert_macros.svh.
//
// Usage:
//   in_valid/in_ready/in_data carry one in_item_t per item. A start item
//   (opcode 0) loads centre, radii and colour and produces no result. A step
//   item (opcode 1) runs one iteration of the walk and produces 1, 2 or 4
//   mirrored pixels on out_valid/out_ready/out_data; the last one carries
//   last_of_step, and finished as well when the walk is over. A step while
//   no ellipse is active produces one empty result with last_of_step and
//   finished set.
//   Rate: one item at a time, set by the microprogram counter that walks a
//   single shared 2R x (R+2) multiplier and one add/compare unit. A start
//   runs its load routine from acceptance back to ready. A step runs its
//   products and compares, one emit microstep per pixel, and then the
//   advance in x and in y before the next step item can be accepted.
//   Reset (rst_n low, synchronous) returns the sequencer to idle, drops any
//   pending result and marks no ellipse active.
//   When the receiver stalls, the sequencer holds on its emit step until the
//   output register frees; a last result may still wait in that register
//   while the next item is accepted.
`include "assert_macros.svh"

module ellipse_outline_rasterizer import eor_pkg::*; #(
  parameter int unsigned RADIUS_BITS = RADIUS_BITS_DEF,
  parameter int unsigned COORD_BITS  = COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  // Widths of the walk: squares, positions, products, criteria, error terms.
  localparam int unsigned SQ_W   = 2 * RADIUS_BITS;
  localparam int unsigned PX_W   = RADIUS_BITS + 1;
  localparam int unsigned PY_W   = RADIUS_BITS + 2;
  localparam int unsigned PROD_W = SQ_W + PY_W + 1;
  localparam int unsigned CRIT_W = 2 * RADIUS_BITS + 4;
  localparam int unsigned ERR_W  = 4 * RADIUS_BITS + 8;

  // Sequencer.
  upc_t  upc_r, upc_nxt;
  ctrl_t cw_cur;

  // Walk state.
  logic                     active_r, active_nxt;
  logic        [PX_W-1:0]   pos_x_r, pos_x_nxt;
  logic signed [PY_W-1:0]   pos_y_r, pos_y_nxt;
  logic signed [COORD_BITS-1:0] cx_r, cx_nxt;
  logic signed [COORD_BITS-1:0] cy_r, cy_nxt;
  logic [RADIUS_BITS-1:0]   rad_h_r, rad_h_nxt;
  logic [15:0]              colour_r, colour_nxt;
  logic [SQ_W-1:0]          sq_h_r, sq_h_nxt;
  logic [SQ_W-1:0]          sq_v_r, sq_v_nxt;
  logic signed [CRIT_W-1:0] crit_r [3];
  logic signed [CRIT_W-1:0] crit_nxt [3];
  logic signed [ERR_W-1:0]  err_r, err_nxt;
  logic signed [ERR_W-1:0]  dxt_r, dxt_nxt;
  logic signed [ERR_W-1:0]  dyt_r, dyt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic                     flag_a_r, flag_a_nxt;
  logic                     flag_b_r, flag_b_nxt;
  logic                     le_c_r, le_c_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  // Datapath signals.
  logic                     in_fire;
  logic                     out_free;
  logic                     emit_op;
  logic                     emit_fire;
  logic [SQ_W-1:0]          mul_a;
  logic signed [PY_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [ERR_W-1:0]  prod_x;
  logic signed [ERR_W-1:0]  cmp_lhs;
  logic signed [ERR_W-1:0]  cmp_rhs;
  logic                     cmp_le;
  logic                     incx;
  logic                     decy;
  logic        [PX_W-1:0]   x_new;
  logic signed [PY_W-1:0]   y_new;
  logic                     walk_done;
  logic                     last_emit;
  logic signed [PY_W-1:0]   px_s;
  logic signed [PY_W-1:0]   off_x;
  logic signed [PY_W-1:0]   off_y;
  logic signed [COORD_BITS-1:0] pix_x;
  logic signed [COORD_BITS-1:0] pix_y;
  logic [RADIUS_BITS-1:0]   in_rad_h;
  logic [RADIUS_BITS-1:0]   in_rad_v;

  assign cw_cur    = ucode(upc_r);
  assign in_ready  = (upc_r == U_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign emit_op   = (cw_cur.op == DP_EMIT) || (cw_cur.op == DP_EMPTY);
  assign emit_fire = emit_op && out_free;

  // Radii are taken modulo 2^RADIUS_BITS.
  assign in_rad_h = RADIUS_BITS'(in_data.radius_h);
  assign in_rad_v = RADIUS_BITS'(in_data.radius_v);

  // Direction of the advance, decided by the three compares:
  // step only in x when either inside criterion holds, diagonally when only
  // the third compare holds, else only in y.
  assign incx = flag_a_r || flag_b_r || le_c_r;
  assign decy = !(flag_a_r || flag_b_r);

  // Position after the advance; the walk ends when it leaves the quadrant.
  assign x_new     = pos_x_r + PX_W'(incx);
  assign y_new     = pos_y_r - $signed(PY_W'(decy));
  assign walk_done = y_new[PY_W-1] || (x_new > PX_W'(rad_h_r));

  // Mirrored pixels without duplicates on the axes.
  always_comb begin
    case (cw_cur.quad)
      Q_PP:    last_emit = (pos_x_r == '0) && (pos_y_r == '0);
      Q_NN:    last_emit = (pos_x_r == '0) || (pos_y_r == '0);
      Q_PN:    last_emit = 1'b0;
      Q_NP:    last_emit = 1'b1;
      default: last_emit = 1'b1;
    endcase
  end

  assign px_s  = $signed(PY_W'(pos_x_r));
  assign off_x = ((cw_cur.quad == Q_NN) || (cw_cur.quad == Q_NP)) ? -px_s : px_s;
  assign off_y = ((cw_cur.quad == Q_NN) || (cw_cur.quad == Q_PN)) ? -pos_y_r : pos_y_r;
  assign pix_x = cx_r + COORD_BITS'(off_x);
  assign pix_y = cy_r + COORD_BITS'(off_y);

  // Shared multiplier: unsigned square-sized operand times signed position or radius.
  always_comb begin
    case (cw_cur.mul)
      MUL_AA: begin
        mul_a = SQ_W'(rad_h_r);
        mul_b = $signed(PY_W'(rad_h_r));
      end
      MUL_BB: begin
        mul_a = SQ_W'(pos_y_r[RADIUS_BITS-1:0]);
        mul_b = pos_y_r;
      end
      MUL_HB: begin
        mul_a = sq_h_r;
        mul_b = pos_y_r;
      end
      MUL_VX: begin
        mul_a = sq_v_r;
        mul_b = px_s;
      end
      MUL_HY: begin
        mul_a = sq_h_r;
        mul_b = pos_y_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = PROD_W'($signed({1'b0, mul_a})) * PROD_W'(mul_b);

  // Add/compare unit: error term plus or minus the held product against
  // one criterion.
  assign prod_x  = ERR_W'(prod_r);
  assign cmp_lhs = (cw_cur.op == DP_CMP_C) ? (err_r - prod_x) : (err_r + prod_x);

  always_comb begin
    case (cw_cur.op)
      DP_CMP_A: cmp_rhs = ERR_W'(crit_r[0]);
      DP_CMP_B: cmp_rhs = ERR_W'(crit_r[2]);
      DP_CMP_C: cmp_rhs = ERR_W'(crit_r[1]);
      default:  cmp_rhs = ERR_W'(crit_r[0]);
    endcase
  end

  assign cmp_le = (cmp_lhs <= cmp_rhs);

  // Next microstep.
  always_comb begin
    upc_nxt = upc_r;
    if (!(emit_op && !out_free)) begin
      case (cw_cur.jmp)
        J_WAIT: begin
          if (in_fire) begin
            if (in_data.opcode == OP_STEP) begin
              upc_nxt = active_r ? U_SP0 : U_EMPTY;
            end else begin
              upc_nxt = U_ST0;
            end
          end
        end
        J_NEXT:    upc_nxt = upc_t'(upc_r + 1'b1);
        J_GOTO:    upc_nxt = cw_cur.target;
        J_IF_LAST: upc_nxt = last_emit ? cw_cur.target : upc_t'(upc_r + 1'b1);
        J_IF_NOX:  upc_nxt = !incx ? cw_cur.target : upc_t'(upc_r + 1'b1);
        J_IF_NOY:  upc_nxt = !decy ? cw_cur.target : upc_t'(upc_r + 1'b1);
        default:   upc_nxt = U_IDLE;
      endcase
    end
  end

  // Datapath and output register, driven by the control word.
  always_comb begin
    active_nxt    = active_r;
    pos_x_nxt     = pos_x_r;
    pos_y_nxt     = pos_y_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    rad_h_nxt     = rad_h_r;
    colour_nxt    = colour_r;
    sq_h_nxt      = sq_h_r;
    sq_v_nxt      = sq_v_r;
    crit_nxt      = crit_r;
    err_nxt       = err_r;
    dxt_nxt       = dxt_r;
    dyt_nxt       = dyt_r;
    prod_nxt      = (cw_cur.mul != MUL_OFF) ? mul_p : prod_r;
    flag_a_nxt    = flag_a_r;
    flag_b_nxt    = flag_b_r;
    le_c_nxt      = le_c_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    // Load a new ellipse; any walk in progress is dropped.
    if (in_fire && (in_data.opcode == OP_START)) begin
      active_nxt = 1'b1;
      cx_nxt     = COORD_BITS'(in_data.centre_x);
      cy_nxt     = COORD_BITS'(in_data.centre_y);
      rad_h_nxt  = in_rad_h;
      colour_nxt = in_data.pixel_colour;
      pos_x_nxt  = '0;
      pos_y_nxt  = $signed(PY_W'(in_rad_v));
      dxt_nxt    = '0;
    end

    case (cw_cur.op)
      DP_LD_SQH: sq_h_nxt = prod_r[SQ_W-1:0];
      DP_LD_SQV: sq_v_nxt = prod_r[SQ_W-1:0];
      DP_LD_ERR: begin
        err_nxt     = -prod_x;
        crit_nxt[2] = $signed(CRIT_W'(0) - (CRIT_W'(sq_v_r >> 2) + CRIT_W'(pos_y_r[0])));
      end
      DP_LD_CRIT: begin
        dyt_nxt     = err_r <<< 1;
        crit_nxt[0] = $signed(CRIT_W'(0) - (CRIT_W'(sq_h_r >> 2) + CRIT_W'(rad_h_r[0])
                      + CRIT_W'(sq_v_r)));
        crit_nxt[1] = $signed(CRIT_W'(0) - (CRIT_W'(sq_v_r >> 2) + CRIT_W'(pos_y_r[0])
                      + CRIT_W'(sq_h_r)));
      end
      DP_CMP_A: flag_a_nxt = cmp_le;
      DP_CMP_B: flag_b_nxt = cmp_le;
      DP_CMP_C: le_c_nxt   = cmp_le;
      DP_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.pixel_valid  = 1'b1;
          out_data_nxt.out_x        = 16'(pix_x);
          out_data_nxt.out_y        = 16'(pix_y);
          out_data_nxt.out_colour   = colour_r;
          out_data_nxt.last_of_step = last_emit;
          out_data_nxt.finished     = last_emit && walk_done;
          // Mark the ellipse inactive once the final pixel of the walk is out.
          if (last_emit && walk_done) begin
            active_nxt = 1'b0;
          end
        end
      end
      DP_EMPTY: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.pixel_valid  = 1'b0;
          out_data_nxt.out_x        = '0;
          out_data_nxt.out_y        = '0;
          out_data_nxt.out_colour   = '0;
          out_data_nxt.last_of_step = 1'b1;
          out_data_nxt.finished     = 1'b1;
        end
      end
      DP_DX: begin
        if (incx) begin
          dxt_nxt = dxt_r + $signed(ERR_W'({sq_v_r, 1'b0}));
        end
      end
      DP_EX: begin
        if (incx) begin
          err_nxt   = err_r + dxt_r;
          pos_x_nxt = x_new;
        end
      end
      DP_DY: begin
        if (decy) begin
          dyt_nxt = dyt_r + $signed(ERR_W'({sq_h_r, 1'b0}));
        end
      end
      DP_EY: begin
        if (decy) begin
          err_nxt   = err_r + dyt_r;
          pos_y_nxt = y_new;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state: cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= U_IDLE;
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r       <= upc_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: loaded before use, no reset.
  always_ff @(posedge clk) begin
    pos_x_r    <= pos_x_nxt;
    pos_y_r    <= pos_y_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    rad_h_r    <= rad_h_nxt;
    colour_r   <= colour_nxt;
    sq_h_r     <= sq_h_nxt;
    sq_v_r     <= sq_v_nxt;
    crit_r     <= crit_nxt;
    err_r      <= err_nxt;
    dxt_r      <= dxt_nxt;
    dyt_r      <= dyt_nxt;
    prod_r     <= prod_nxt;
    flag_a_r   <= flag_a_nxt;
    flag_b_r   <= flag_b_nxt;
    le_c_r     <= le_c_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted item always starts a routine, so the block is busy next cycle.
  `EOR_ASSERT_NXT(a_busy_after_accept, in_fire, !in_ready, "ready held after accept")

  // Between items an active walk stays inside its quadrant.
  `EOR_ASSERT_IMP(a_walk_in_range, active_r && (upc_r == U_IDLE),
    !pos_y_r[PY_W-1] && (pos_x_r <= PX_W'(rad_h_r)), "active walk out of range")

  // A result handed to the output register is presented next cycle.
  `EOR_ASSERT_NXT(a_emit_lands, emit_fire, out_valid, "emitted result lost")

endmodule
